// File: rtl/ttsb_pkg.sv
// Shared types and constants for the text terminal scroll buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ttsb_pkg;

  // Item opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Bytes that move the cursor to a new line instead of being stored.
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RWAIT,
    ST_SCROLL
  } ttsb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the item fields
    logic exec;   // run the captured item: store, move cursor, issue read
    logic sweep;  // write zero at the sweep position and advance it
    logic emit;   // register the result and raise the strobe
  } ttsb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic scroll_needed;
    logic sweep_col_last;
    logic sweep_row_last;
  } ttsb_status_t;

endpackage

// File: rtl/ttsb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module ttsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ttsb_ctrl.sv
// Controller state machine of the text terminal scroll buffer.
// Depends on ttsb_pkg for the state, command and status types.
`timescale 1ns / 1ps

module ttsb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ttsb_pkg::ttsb_status_t status,
  output ttsb_pkg::ttsb_cmd_t    cmd,
  output logic                  busy
);
  import ttsb_pkg::*;

  ttsb_state_t state;
  ttsb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_CLEAR: begin
        // Sweep every cell to zero after reset.
        cmd.sweep = 1'b1;
        if (status.sweep_col_last && status.sweep_row_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.is_read) begin
          state_next = ST_RWAIT;
        end else if (status.scroll_needed) begin
          state_next = ST_SCROLL;
        end else begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RWAIT: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        cmd.sweep = 1'b1;
        if (status.sweep_col_last) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/ttsb_dp.sv
// Datapath of the text terminal scroll buffer: item registers, cursor, scroll
// offset, clear sweep counters, the screen RAM and the result registers.
// Depends on ttsb_pkg and ttsb_ram.
`timescale 1ns / 1ps

module ttsb_dp #(
  parameter int SCREEN_ROWS = 32,
  parameter int SCREEN_COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ttsb_pkg::ttsb_cmd_t    cmd,
  output ttsb_pkg::ttsb_status_t status,
  input  logic                  opcode,
  input  logic [7:0]            char_in,
  input  logic [4:0]            read_row,
  input  logic [5:0]            read_col,
  output logic                  done,
  output logic [7:0]            read_char,
  output logic [5:0]            cursor_col,
  output logic [4:0]            cursor_row
);
  import ttsb_pkg::*;

  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int COL_W  = $clog2(SCREEN_COLS);
  localparam int ROW_W1 = ROW_W + 1;
  localparam int DEPTH  = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W:0]    ROWS_E   = ROW_W1'(SCREEN_ROWS);
  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(SCREEN_COLS);

  // Item registers.
  logic       op_q;
  logic [7:0] char_q;
  logic [4:0] rrow_q;
  logic [5:0] rcol_q;

  // Cursor and scroll state.
  logic [COL_W-1:0] ccol, ccol_next;
  logic [ROW_W-1:0] crow, crow_next;
  logic [ROW_W-1:0] top, top_next;

  // Clear sweep position.
  logic [ROW_W-1:0] sweep_row;
  logic [COL_W-1:0] sweep_col;

  logic             is_write, is_nl, wrap, newline_evt, at_bottom;
  logic             rd_in_range;
  logic [ROW_W-1:0] rrow_n;
  logic [COL_W-1:0] rcol_n;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                input logic [ROW_W-1:0] vis);
    logic [ROW_W:0] sum;
    sum = {1'b0, base} + {1'b0, vis};
    if (sum >= ROWS_E) begin
      sum = sum - ROWS_E;
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * COLS_A + ADDR_W'(col);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      char_q <= char_in;
      rrow_q <= read_row;
      rcol_q <= read_col;
    end
  end

  assign is_write    = (op_q == OP_WRITE);
  assign is_nl       = (char_q == CHAR_LF) || (char_q == CHAR_CR);
  assign wrap        = !is_nl && (ccol == LAST_COL);
  assign newline_evt = is_write && (is_nl || wrap);
  assign at_bottom   = (crow == LAST_ROW);

  assign rd_in_range = (32'(rrow_q) < SCREEN_ROWS) && (32'(rcol_q) < SCREEN_COLS);
  assign rrow_n      = ROW_W'(rrow_q);
  assign rcol_n      = COL_W'(rcol_q);

  assign status.is_read        = !is_write;
  assign status.scroll_needed  = newline_evt && at_bottom;
  assign status.sweep_col_last = (sweep_col == LAST_COL);
  assign status.sweep_row_last = (sweep_row == LAST_ROW);

  always_comb begin
    ccol_next = ccol;
    crow_next = crow;
    top_next  = top;
    if (cmd.exec && is_write) begin
      if (newline_evt) begin
        ccol_next = '0;
        if (at_bottom) begin
          top_next = (top == LAST_ROW) ? '0 : top + 1'b1;
        end else begin
          crow_next = crow + 1'b1;
        end
      end else begin
        ccol_next = ccol + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ccol <= '0;
      crow <= '0;
      top  <= '0;
    end else begin
      ccol <= ccol_next;
      crow <= crow_next;
      top  <= top_next;
    end
  end

  // The old top row becomes the new bottom row and is swept to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_row <= '0;
      sweep_col <= '0;
    end else if (cmd.exec && status.scroll_needed) begin
      sweep_row <= top;
    end else if (cmd.sweep) begin
      if (sweep_col == LAST_COL) begin
        sweep_col <= '0;
        sweep_row <= (sweep_row == LAST_ROW) ? '0 : sweep_row + 1'b1;
      end else begin
        sweep_col <= sweep_col + 1'b1;
      end
    end
  end

  assign ram_we    = cmd.sweep || (cmd.exec && is_write && !is_nl);
  assign ram_waddr = cmd.sweep ? cell_addr(sweep_row, sweep_col)
                               : cell_addr(phys_row(top, crow), ccol);
  assign ram_wdata = cmd.sweep ? 8'd0 : char_q;
  assign ram_raddr = cell_addr(phys_row(top, rrow_n), rcol_n);

  ttsb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      read_char  <= (!is_write && rd_in_range) ? ram_rdata : 8'd0;
      cursor_col <= 6'(ccol_next);
      cursor_row <= 5'(crow_next);
    end
  end

endmodule

// File: rtl/text_terminal_scroll_buffer.sv
// Top level of the text terminal scroll buffer: a character screen store
// with cursor and scrolling. Depends on ttsb_pkg, ttsb_ctrl and ttsb_dp.
`timescale 1ns / 1ps

// Channel   Handshake              Beat fields
// -------   ---------------------  -------------------------------------------
// item in   start high, busy low   opcode, char_in, read_row, read_col
// result    done high, one cycle   read_char, cursor_col, cursor_row
//
// A plain character write or a new line without scrolling shows its result
// after the execute state, and a read after the read wait state. A write
// that scrolls sweeps one row of the screen RAM to zero at one cell per
// cycle through its single write port, then shows its result.
// After reset the same sweep clears the whole store, all SCREEN_ROWS *
// SCREEN_COLS cells (2048 by default), and busy stays high until it ends.
// The receiver cannot stall: done is high for exactly one cycle per item.

module text_terminal_scroll_buffer #(
  parameter int SCREEN_ROWS = 32,
  parameter int SCREEN_COLS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       opcode,
  input  logic [7:0] char_in,
  input  logic [4:0] read_row,
  input  logic [5:0] read_col,
  output logic       done,
  output logic [7:0] read_char,
  output logic [5:0] cursor_col,
  output logic [4:0] cursor_row
);
  import ttsb_pkg::*;

  ttsb_cmd_t    cmd;
  ttsb_status_t status;

  // The controller sequences the clear sweep, item execution, the read wait
  // and the scroll sweep; it alone decides when the block is busy.
  ttsb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the cursor, the visible top row, the screen RAM and
  // the result registers. Scrolling only rotates the top row pointer; the
  // row that falls off the top is the one that gets blanked.
  ttsb_dp #(
    .SCREEN_ROWS(SCREEN_ROWS),
    .SCREEN_COLS(SCREEN_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .opcode    (opcode),
    .char_in   (char_in),
    .read_row  (read_row),
    .read_col  (read_col),
    .done      (done),
    .read_char (read_char),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row)
  );

endmodule

// File: rtl/ttsb_checker.sv
// Port-level checks for the text terminal scroll buffer, bound to its top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module ttsb_checker #(
  parameter int SCREEN_ROWS = 32,
  parameter int SCREEN_COLS = 64
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [5:0] cursor_col,
  input logic [4:0] cursor_row
);

  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // A result never appears in the cycle right after an acceptance.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(start && !busy))
    else $error("result strobe too soon after acceptance");

  // One item at a time: result strobes are never adjacent.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // The block is ready again while a result is shown.
  a_ready_at_result: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("block busy while presenting a result");

  // The reported cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((32'(cursor_col) < SCREEN_COLS) || (SCREEN_COLS > 64)) &&
             ((32'(cursor_row) < SCREEN_ROWS) || (SCREEN_ROWS > 32)))
    else $error("cursor outside the screen");

endmodule

bind text_terminal_scroll_buffer ttsb_checker #(
  .SCREEN_ROWS(SCREEN_ROWS),
  .SCREEN_COLS(SCREEN_COLS)
) u_ttsb_checker (.*);

// File: tb/sv/text_terminal_scroll_buffer_tb.sv
// Self-checking testbench for text_terminal_scroll_buffer: drives write and read
// items, tracks the screen, cursor and scroll position, and checks every result.
// Depends on ttsb_pkg and the text_terminal_scroll_buffer RTL.
`timescale 1ns / 1ps

// One result beat as the block should report it.
typedef struct {
  logic [7:0] read_char;
  logic [5:0] cursor_col;
  logic [4:0] cursor_row;
} screen_reply_t;

// Tracks the terminal screen the way the block should: the cells, the cursor
// and the physical row shown on top. Each accepted item yields one reply.
class screen_tracker;
  localparam int ROWS = 32;
  localparam int COLS = 64;

  logic [7:0]    cells [0:ROWS*COLS-1];
  int unsigned   cur_col;
  int unsigned   cur_line;
  int unsigned   top_row;
  screen_reply_t awaited_replies [$];
  int            errors;

  function new();
    for (int i = 0; i < ROWS * COLS; i++) begin
      cells[i] = 8'h00;
    end
    cur_col  = 0;
    cur_line = 0;
    top_row  = 0;
    errors   = 0;
  endfunction

  // Cursor to column 0 of the next row. On the bottom row the old top row
  // rotates to the bottom and is blanked, and the cursor stays on the bottom row.
  function void line_break();
    cur_col = 0;
    if (cur_line + 1 >= ROWS) begin
      for (int c = 0; c < COLS; c++) begin
        cells[top_row * COLS + c] = 8'h00;
      end
      top_row  = (top_row + 1) % ROWS;
      cur_line = ROWS - 1;
    end else begin
      cur_line++;
    end
  endfunction

  function void accept_item(logic op, logic [7:0] ch, logic [4:0] row, logic [5:0] col);
    screen_reply_t reply;
    reply.read_char = 8'h00;
    if (op == ttsb_pkg::OP_WRITE) begin
      if (ch == ttsb_pkg::CHAR_LF || ch == ttsb_pkg::CHAR_CR) begin
        line_break();
      end else begin
        cells[((top_row + cur_line) % ROWS) * COLS + cur_col] = ch;
        cur_col++;
        if (cur_col >= COLS) begin
          line_break();
        end
      end
    end else if (row < ROWS && col < COLS) begin
      reply.read_char = cells[((top_row + row) % ROWS) * COLS + col];
    end
    reply.cursor_col = cur_col[5:0];
    reply.cursor_row = cur_line[4:0];
    awaited_replies.push_back(reply);
  endfunction

  function void compare_result(logic [7:0] rc, logic [5:0] cc, logic [4:0] cr);
    screen_reply_t want;
    if (awaited_replies.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: result with nothing outstanding: char=%0h col=%0d row=%0d",
                 rc, cc, cr);
      end
    end else begin
      want = awaited_replies.pop_front();
      if (rc !== want.read_char || cc !== want.cursor_col || cr !== want.cursor_row) begin
        errors++;
        if (errors <= 10) begin
          $display({"ERROR: result mismatch: expected char=%0h col=%0d row=%0d,",
                    " got char=%0h col=%0d row=%0d"},
                   want.read_char, want.cursor_col, want.cursor_row, rc, cc, cr);
        end
      end
    end
  endfunction
endclass

module text_terminal_scroll_buffer_tb;
  import ttsb_pkg::*;

  // Cycles with neither an accepted item nor a result before the run is
  // declared hung. The slowest honest stretch is the clearing pass after
  // reset plus the longest sender gap, so this is generous.
  localparam int STALL_LIMIT = 10000;
  // Random items to send after the directed part.
  localparam int RANDOM_ITEMS = 1400;
  // Quiet time after the last result, long enough for a scrolling write to
  // finish, so anything stray would show up before this ends.
  localparam int TAIL_CYCLES = 100;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       opcode;
  logic [7:0] char_in;
  logic [4:0] read_row;
  logic [5:0] read_col;
  logic       done;
  logic [7:0] read_char;
  logic [5:0] cursor_col;
  logic [4:0] cursor_row;

  screen_tracker board;
  int            stall_cycles;
  // When set, the sender puts no gaps between beats.
  bit            back_to_back;

  text_terminal_scroll_buffer dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .char_in    (char_in),
    .read_row   (read_row),
    .read_col   (read_col),
    .done       (done),
    .read_char  (read_char),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Observe both channels at the rising edge. Blocking reads here see the
  // values from before the edge, which is what the block itself samples.
  // A result beat is checked before a new item is logged; the block never
  // reports an item in the same cycle it accepts it, so order is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        board.compare_result(read_char, cursor_col, cursor_row);
      end
      if (start && !busy) begin
        board.accept_item(opcode, char_in, read_row, read_col);
      end
    end
  end

  // Watchdog on forward progress. The clearing pass after reset counts
  // toward it too, which the limit allows for.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one so that idle time falls on
  // every phase of a scroll sweep.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (back_to_back || roll < 40) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(3, 1);
    end else if (roll < 97) begin
      return $urandom_range(12, 4);
    end else begin
      return $urandom_range(70, 20);
    end
  endfunction

  // While start is low the payload ports carry junk; the block must ignore it.
  task automatic scramble_fields();
    opcode   = 1'($urandom_range(1));
    char_in  = 8'($urandom_range(255));
    read_row = 5'($urandom_range(31));
    read_col = 6'($urandom_range(63));
  endtask

  // Present one item from the falling edge on and hold it until a rising
  // edge finds busy low. Then optionally idle for a random gap.
  task automatic send_item(input logic op, input logic [7:0] ch,
                           input logic [4:0] row, input logic [5:0] col);
    int gap;
    @(negedge clk);
    start    = 1'b1;
    opcode   = op;
    char_in  = ch;
    read_row = row;
    read_col = col;
    do begin
      @(posedge clk);
    end while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      scramble_fields();
      repeat (gap - 1) begin
        @(negedge clk);
        scramble_fields();
      end
    end
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_item(OP_WRITE, ch, 5'($urandom_range(31)), 6'($urandom_range(63)));
  endtask

  task automatic peek_cell(input logic [4:0] row, input logic [5:0] col);
    send_item(OP_READ, 8'($urandom_range(255)), row, col);
  endtask

  // Random beats in bursts. Each burst picks how often a line ends, so that
  // some lines run long enough to wrap, and how often reads come. Reads lean
  // toward the cursor row, where freshly written text is, and otherwise
  // range over the whole screen.
  task automatic random_traffic();
    int          sent;
    int          burst_left;
    int          break_pct;
    int          read_pct;
    int          roll;
    logic [7:0]  ch;
    logic [4:0]  row;
    sent       = 0;
    burst_left = 0;
    break_pct  = 5;
    read_pct   = 25;
    while (sent < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left   = $urandom_range(80, 20);
        roll         = $urandom_range(2);
        break_pct    = (roll == 0) ? 0 : (roll == 1) ? 6 : 35;
        read_pct     = $urandom_range(40, 5);
        back_to_back = ($urandom_range(3) == 0);
      end
      burst_left--;
      sent++;
      roll = $urandom_range(99);
      if (roll < read_pct) begin
        if ($urandom_range(1) == 0) begin
          row = board.cur_line[4:0];
        end else begin
          row = 5'($urandom_range(31));
        end
        peek_cell(row, 6'($urandom_range(63)));
      end else begin
        roll = $urandom_range(99);
        if (roll < break_pct) begin
          ch = ($urandom_range(1) == 0) ? CHAR_LF : CHAR_CR;
        end else if (roll < 80) begin
          ch = 8'($urandom_range(126, 32));
        end else begin
          ch = 8'($urandom_range(255));
        end
        put_char(ch);
      end
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    board        = new();
    back_to_back = 1'b0;
    stall_cycles = 0;
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = OP_WRITE;
    char_in      = 8'h00;
    read_row     = 5'd0;
    read_col     = 6'd0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed part. The first beat waits out the clearing pass after reset.
    peek_cell(5'd0, 6'd0);       // cleared store reads zero
    peek_cell(5'd31, 6'd63);     // far corner of the screen
    put_char(8'h00);             // a zero byte is stored and moves the cursor
    put_char(8'hFF);
    put_char(8'h41);
    peek_cell(5'd0, 6'd1);
    peek_cell(5'd0, 6'd2);
    put_char(CHAR_CR);           // carriage return gives a new line
    put_char(8'h7F);
    put_char(CHAR_LF);           // line feed does the same
    put_char(CHAR_LF);
    put_char(8'h80);
    put_char(CHAR_CR);
    put_char(CHAR_LF);           // back-to-back line ends give two new lines
    put_char(8'h5A);
    peek_cell(5'd1, 6'd0);
    peek_cell(5'd3, 6'd0);
    peek_cell(5'd6, 6'd0);
    peek_cell(5'd0, 6'd0);

    // Run the cursor down to the bottom row so that the directed part also
    // covers a new line on the last row, which scrolls, and the row that
    // scrolled off being reused as a blank bottom row.
    while (board.cur_line < 31) begin
      put_char(CHAR_LF);
    end
    put_char(8'h31);
    put_char(CHAR_LF);
    peek_cell(5'd30, 6'd0);
    peek_cell(5'd31, 6'd0);
    peek_cell(5'd0, 6'd0);

    // A full last line wraps and scrolls just like a line end.
    while (board.cur_col < 63) begin
      put_char(8'($urandom_range(126, 32)));
    end
    put_char(8'h7E);
    peek_cell(5'd30, 6'd63);
    peek_cell(5'd31, 6'd63);

    random_traffic();

    // Let the line settle, then wait for every outstanding result.
    @(negedge clk);
    start = 1'b0;
    while (board.awaited_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    // Anything still outstanding was never reported.
    if (board.awaited_replies.size() != 0) begin
      board.errors += board.awaited_replies.size();
    end
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
